// ===== src/cflp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cflp_pkg: shared types, constants and functions
// Widths, register indexes, end-state codes, controller states and the
// wrap and pan helpers of the crossfade loop phasor.
// ----------------------------------------------------------------------------
package cflp_pkg;

  localparam int PosW     = 48;
  localparam int SumW     = PosW + 2;
  localparam int RateW    = 24;
  localparam int OvW      = 24;
  localparam int PanW     = 16;
  localparam int FracW    = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 48;
  localparam int CntW     = 6;

  localparam logic [CfgIdxW-1:0] CFG_START   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_END     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RESET   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LOOP    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_OVERLAP = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_INITFWD = 3'd5;

  localparam logic [1:0] ES_RUN   = 2'd0;
  localparam logic [1:0] ES_END   = 2'd1;
  localparam logic [1:0] ES_START = 2'd2;

  localparam logic [PanW-1:0] PAN_NONE = 16'h8000;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_TRIG = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_STEP = 5'b10000
  } cflp_state_e;

  typedef struct packed {
    logic capture;
    logic trig;
    logic load;
    logic step;
  } cflp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } cflp_status_t;

  // Wraps one step back into [lo, hi), then clamps; an empty range holds at lo.
  function automatic logic [PosW-1:0] wrap_once(input logic signed [SumW-1:0] s,
                                                input logic signed [SumW-1:0] lo,
                                                input logic signed [SumW-1:0] hi);
    logic signed [SumW-1:0] r;
    logic signed [SumW-1:0] span;
    begin
      r    = s;
      span = hi - lo;
      if (hi <= lo) begin
        r = lo;
      end else begin
        if (r >= hi) begin
          r = r - span;
        end else if (r < lo) begin
          r = r + span;
        end
        if (r < lo) r = lo;
        if (r >= hi) r = hi - 50'sd1;
      end
      return r[PosW-1:0];
    end
  endfunction

  // Pan is 32768 minus the quotient, saturated to the Q1.15 range.
  function automatic logic [PanW-1:0] make_pan(input logic [PosW-1:0] q);
    logic [PanW:0] diff;
    begin
      diff = 17'd32768 - {1'b0, q[PanW-1:0]};
      if (q[PosW-1:PanW] != '0) return PAN_NONE;
      if (q == '0) return 16'h7FFF;
      return diff[PanW-1:0];
    end
  endfunction

endpackage

// ===== src/cflp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cflp_in_if: input channel
// Valid/ready channel that carries one trigger level and one step rate.
// ----------------------------------------------------------------------------
interface cflp_in_if;
  logic               valid;
  logic               ready;
  logic               trigger_high;
  logic signed [23:0] step_rate;

  modport source (output valid, trigger_high, step_rate, input ready);
  modport sink   (input valid, trigger_high, step_rate, output ready);
endinterface

// ===== src/cflp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cflp_out_if: result channel
// Valid/ready channel that carries the phases, pans and moving flag.
// ----------------------------------------------------------------------------
interface cflp_out_if;
  logic               valid;
  logic               ready;
  logic [47:0]        main_phase;
  logic [47:0]        tail_phase;
  logic signed [15:0] main_pan;
  logic [47:0]        old_phase;
  logic [47:0]        old_tail_phase;
  logic signed [15:0] old_pan;
  logic signed [15:0] fade_pan;
  logic               moving;

  modport source (output valid, main_phase, tail_phase, main_pan, old_phase,
                  old_tail_phase, old_pan, fade_pan, moving, input ready);
  modport sink   (input valid, main_phase, tail_phase, main_pan, old_phase,
                  old_tail_phase, old_pan, fade_pan, moving, output ready);
endinterface

// ===== src/cflp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cflp_div: iterative pan divider
// Restoring division, one quotient bit per cycle, followed by the pan map.
// ----------------------------------------------------------------------------
module cflp_div
  import cflp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [PosW-1:0]  dividend_i,
  input  logic [OvW-1:0]   divisor_i,
  output logic             busy_o,
  output logic [PanW-1:0]  pan_o
);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [OvW-1:0]  rem_q, rem_d;
  logic [PosW-1:0] quo_q;
  logic [OvW-1:0]  div_q;
  logic [OvW:0]    trial;
  logic            fits;

  assign trial = {rem_q, quo_q[PosW-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    if (fits) begin
      rem_d = OvW'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[OvW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(PosW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[PosW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign pan_o  = make_pan(quo_q);

endmodule

// ===== src/cflp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cflp_datapath: phasor state, configuration and result register
// Holds the positions and crossfade state, runs the three pan dividers and
// drives the result beat.
// ----------------------------------------------------------------------------
module cflp_datapath
  import cflp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cflp_cmd_t              cmd_i,
  output cflp_status_t           status_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [CfgDataW-1:0]    cfg_data_i,
  input  logic                   trigger_high_i,
  input  logic signed [RateW-1:0] step_rate_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [PosW-1:0]        main_phase_o,
  output logic [PosW-1:0]        tail_phase_o,
  output logic [PanW-1:0]        main_pan_o,
  output logic [PosW-1:0]        old_phase_o,
  output logic [PosW-1:0]        old_tail_phase_o,
  output logic [PanW-1:0]        old_pan_o,
  output logic [PanW-1:0]        fade_pan_o,
  output logic                   moving_o
);

  // Configuration. The initial direction flag only shapes the reset state,
  // which is fixed by the register reset values, so it is not stored.
  logic [PosW-1:0] start_q, end_q, rpos_q;
  logic            loop_q;
  logic [OvW-1:0]  ovl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      end_q   <= '0;
      rpos_q  <= '0;
      loop_q  <= 1'b0;
      ovl_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START:   start_q <= cfg_data_i[PosW-1:0];
        CFG_END:     end_q   <= cfg_data_i[PosW-1:0];
        CFG_RESET:   rpos_q  <= cfg_data_i[PosW-1:0];
        CFG_LOOP:    loop_q  <= cfg_data_i[0];
        CFG_OVERLAP: ovl_q   <= cfg_data_i[OvW-1:0];
        CFG_INITFWD: ;
        default:     ;
      endcase
    end
  end

  // Effective overlap and pan divisor, refreshed every cycle.
  logic [PosW-1:0] range_w;
  logic [OvW-1:0]  ov_d, ov_q, dv_d, dv_q;
  logic [PosW-1:0] ovp;

  assign range_w = end_q - start_q;

  always_comb begin
    if (end_q <= start_q) begin
      ov_d = '0;
    end else if ({7'd0, ovl_q} < range_w[PosW-1:FracW+1]) begin
      ov_d = ovl_q;
    end else begin
      ov_d = range_w[FracW+OvW:FracW+1];
    end
    dv_d = (ov_q >= OvW'(2)) ? ov_q - 1'b1 : OvW'(1);
  end

  always_ff @(posedge clk_i) begin
    ov_q <= ov_d;
    dv_q <= dv_d;
  end

  assign ovp = {8'd0, ov_q, 16'd0};

  // Captured input beat.
  logic                    trig_q;
  logic signed [RateW-1:0] rate_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      trig_q <= trigger_high_i;
      rate_q <= step_rate_i;
    end
  end

  // Phasor state.
  logic            prev_q, fading_q, fp_q;
  logic [PosW-1:0] pos_q, old_q;
  logic [1:0]      es_q, oes_q;
  logic [OvW-1:0]  fc_q;

  logic            rise, fp_set;
  logic [PosW-1:0] jump;

  assign rise   = !prev_q && trig_q;
  assign jump   = (rpos_q < start_q) ? start_q : rpos_q;
  assign fp_set = ({1'b0, rpos_q} < ({1'b0, start_q} + {1'b0, ovp})) &&
                  (rate_q > 24'sd0);

  // Next state after the position advance.
  logic signed [SumW-1:0] rate_x, lo, hi, lim, s, o, c;
  logic [PosW-1:0]        pos_d, old_d;
  logic [1:0]             es_d, oes_d;
  logic [OvW-1:0]         fc_d;

  assign rate_x = SumW'(rate_q);
  assign lo     = $signed({2'b00, start_q});
  assign hi     = $signed({2'b00, end_q});
  assign lim    = hi - $signed({2'b00, ovp});
  assign s      = $signed({2'b00, pos_q}) + rate_x;
  assign o      = $signed({2'b00, old_q}) + ((oes_q == ES_RUN) ? rate_x : '0);
  assign fc_d   = fc_q + 1'b1;

  // In clamp mode the start check comes first and the end check sees its
  // result, so an inverted range always ends at the end position.
  always_comb begin
    es_d = ES_RUN;
    c    = s;
    if (loop_q) begin
      pos_d = wrap_once(s, lo, hi);
    end else begin
      if (c < lo) begin
        c    = lo;
        es_d = ES_START;
      end
      if (c > hi) begin
        c    = hi;
        es_d = ES_END;
      end
      pos_d = c[PosW-1:0];
    end
    oes_d = oes_q;
    if (loop_q) begin
      old_d = wrap_once(o, lo, lim);
    end else if (o >= hi) begin
      old_d = end_q;
      oes_d = ES_END;
    end else if (o <= lo) begin
      old_d = start_q;
      oes_d = ES_START;
    end else begin
      old_d = o[PosW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= 1'b1;
      pos_q    <= '0;
      es_q     <= ES_RUN;
      fading_q <= 1'b0;
      old_q    <= '0;
      fc_q     <= '0;
      oes_q    <= ES_RUN;
      fp_q     <= 1'b0;
    end else if (cmd_i.trig) begin
      prev_q <= trig_q;
      if (rise) begin
        old_q    <= pos_q;
        oes_q    <= es_q;
        fc_q     <= '0;
        fading_q <= 1'b1;
        if (fp_set) fp_q <= 1'b1;
        pos_q    <= jump;
        es_q     <= ES_RUN;
      end
    end else if (cmd_i.step) begin
      pos_q <= pos_d;
      es_q  <= es_d;
      if (fp_q && pos_d > ovp) fp_q <= 1'b0;
      if (fading_q) begin
        fc_q  <= fc_d;
        if (fc_d >= ov_q) fading_q <= 1'b0;
        old_q <= old_d;
        oes_q <= oes_d;
      end
    end
  end

  // Result staging, captured before the advance.
  logic            tail_act, otail_act;
  logic [PosW-1:0] st_main_q, st_tail_q, st_old_q, st_otail_q;
  logic            st_tact_q, st_oact_q, st_fad_q, st_mov_q;

  assign tail_act  = loop_q && (pos_q < ovp) && !fp_q;
  assign otail_act = loop_q && (old_q < ovp);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      st_main_q  <= pos_q;
      st_tail_q  <= tail_act ? pos_q + end_q - ovp : '0;
      st_tact_q  <= tail_act;
      st_fad_q   <= fading_q;
      st_old_q   <= fading_q ? old_q : '0;
      st_otail_q <= (fading_q && otail_act) ? old_q + end_q - ovp : '0;
      st_oact_q  <= fading_q && otail_act;
      st_mov_q   <= es_q == ES_RUN;
    end
  end

  logic            busy_m, busy_o_w, busy_f;
  logic [PanW-1:0] pan_m, pan_o_w, pan_f;

  cflp_div u_div_main (
    .clk_i, .rst_ni, .start_i(cmd_i.load), .dividend_i(pos_q), .divisor_i(dv_q),
    .busy_o(busy_m), .pan_o(pan_m)
  );
  cflp_div u_div_old (
    .clk_i, .rst_ni, .start_i(cmd_i.load), .dividend_i(old_q), .divisor_i(dv_q),
    .busy_o(busy_o_w), .pan_o(pan_o_w)
  );
  cflp_div u_div_fade (
    .clk_i, .rst_ni, .start_i(cmd_i.load), .dividend_i({8'd0, fc_q, 16'd0}),
    .divisor_i(dv_q), .busy_o(busy_f), .pan_o(pan_f)
  );

  // Result register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      main_phase_o     <= st_main_q;
      tail_phase_o     <= st_tail_q;
      main_pan_o       <= st_tact_q ? pan_m : PAN_NONE;
      old_phase_o      <= st_old_q;
      old_tail_phase_o <= st_otail_q;
      old_pan_o        <= st_oact_q ? pan_o_w : PAN_NONE;
      fade_pan_o       <= st_fad_q ? pan_f : PAN_NONE;
      moving_o         <= st_mov_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.div_busy = busy_m || busy_o_w || busy_f;
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

// ===== src/cflp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cflp_ctrl: sequencing state machine
// Walks one beat through capture, trigger, load, divide and advance.
// ----------------------------------------------------------------------------
module cflp_ctrl
  import cflp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  cflp_status_t status_i,
  output cflp_cmd_t    cmd_o
);

  cflp_state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = ST_TRIG;
      end
      ST_TRIG: begin
        cmd_o.trig = 1'b1;
        state_d    = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        if (!status_i.div_busy) state_d = ST_STEP;
      end
      ST_STEP: begin
        cmd_o.step = status_i.out_free;
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == ST_IDLE;

endmodule

// ===== src/crossfade_loop_phasor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crossfade_loop_phasor_unit: triggered phasor with loop-tail crossfade
// Top level: controller, datapath and the two valid/ready channels.
// ----------------------------------------------------------------------------
// Each input beat is one audio sample and yields exactly one result beat.
// From acceptance a beat passes through capture, trigger handling and
// loading, the three restoring pan dividers that run side by side with one
// quotient bit per cycle, a state that sees them finish, and the advance of
// the position, which waits until the output register is free. A new beat
// is accepted as soon as the previous one has been advanced, even while its
// result still waits in the output register. Configuration is written
// through the write port while the block is idle; the effective overlap
// follows in the cycle after a write.
// ----------------------------------------------------------------------------
module crossfade_loop_phasor_unit
  import cflp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  cflp_in_if.sink             in_i,
  cflp_out_if.source          out_o
);

  cflp_cmd_t    cmd;
  cflp_status_t status;
  logic [PanW-1:0] main_pan, old_pan, fade_pan;

  // The controller sequences the work; the datapath holds the phasor and configuration state.
  cflp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cflp_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .trigger_high_i   (in_i.trigger_high),
    .step_rate_i      (in_i.step_rate),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .main_phase_o     (out_o.main_phase),
    .tail_phase_o     (out_o.tail_phase),
    .main_pan_o       (main_pan),
    .old_phase_o      (out_o.old_phase),
    .old_tail_phase_o (out_o.old_tail_phase),
    .old_pan_o        (old_pan),
    .fade_pan_o       (fade_pan),
    .moving_o         (out_o.moving)
  );

  assign out_o.main_pan = $signed(main_pan);
  assign out_o.old_pan  = $signed(old_pan);
  assign out_o.fade_pan = $signed(fade_pan);

  // The block is busy for the cycle after it takes a beat.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input ready right after an accepted beat");

  // A result only appears while a beat is being worked on.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(!in_i.ready))
    else $error("result appeared without a beat in work");

  // A stalled result holds its value.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.main_phase))
    else $error("stalled result changed");

endmodule

// ===== sim/crossfade_loop_phasor_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crossfade_loop_phasor_unit_test: self-checking bench of the loop phasor
// Drives trigger and rate beats under several loop, clamp and overlap
// settings, predicts every result beat in the bench and compares each field.
// ----------------------------------------------------------------------------
module crossfade_loop_phasor_unit_test;
  import cflp_pkg::*;

  localparam longint M48 = 64'hFFFF_FFFF_FFFF;
  localparam longint M24 = 64'hFF_FFFF;
  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles = 70;

  // One result beat as the block should present it.
  typedef struct packed {
    logic [47:0] main_phase;
    logic [47:0] tail_phase;
    logic [15:0] main_pan;
    logic [47:0] old_phase;
    logic [47:0] old_tail_phase;
    logic [15:0] old_pan;
    logic [15:0] fade_pan;
    logic        moving;
  } phasor_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CFG_START;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  cflp_in_if  in_ch ();
  cflp_out_if out_ch ();

  crossfade_loop_phasor_unit dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_ch.sink),
    .out_o     (out_ch.source)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.trigger_high = 1'b0;
    in_ch.step_rate = '0;
    out_ch.ready = 1'b0;
  end

  // Bench copy of the registers.
  longint loop_start, loop_end, jump_pos, fade_len;
  logic   wrap_on, fwd_at_init;

  // Bench copy of the phasor state.
  logic   last_trig;
  longint play_pos, old_pos, fade_cnt;
  logic [1:0] play_code, old_code;
  logic   fade_on, first_lap;

  phasor_beat_t pending_beats[$];
  int     fail_count = 0;
  int     beats_sent = 0;
  int     beats_checked = 0;
  int     fades_started = 0;
  int     wraps_seen = 0;

  // Sender and receiver idling controls.
  logic   idle_on = 1'b1;
  logic   hold_request = 1'b0;
  int     hold_cycles = 0;
  int     stall_left = 0;
  int     quiet_cycles = 0;

  // Effective overlap in whole samples: limited to half the loop range.
  function automatic longint overlap_frames();
    longint half;
    if (loop_end <= loop_start) return 0;
    half = (loop_end - loop_start) >>> 17;
    return (fade_len < half) ? fade_len : half;
  endfunction

  function automatic logic [15:0] pan_value(longint p, longint d);
    longint v;
    v = 32768 - p / d;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // One wrap back into [lo, hi), then a clamp; an empty range holds at lo.
  function automatic longint wrap_step(longint s, longint lo, longint hi);
    if (hi <= lo) return lo;
    if (s >= hi) s = s - (hi - lo);
    else if (s < lo) s = s + (hi - lo);
    if (s < lo) s = lo;
    if (s >= hi) s = hi - 1;
    return s;
  endfunction

  function automatic longint jump_target();
    return (jump_pos < loop_start) ? loop_start : jump_pos;
  endfunction

  // Works out the result of one accepted sample and advances the bench state.
  function automatic phasor_beat_t advance_phasor(logic trig, logic signed [23:0] rate_in);
    phasor_beat_t b;
    longint ov, ovp, d, r, s, o, lim;
    ov = overlap_frames();
    ovp = ov <<< 16;
    d = (ov >= 2) ? ov - 1 : 1;
    r = rate_in;

    if (!last_trig && trig) begin
      old_pos = play_pos;
      old_code = play_code;
      fade_cnt = 0;
      fade_on = 1'b1;
      if (jump_pos < loop_start + ovp && r > 0) first_lap = 1'b1;
      play_pos = jump_target();
      play_code = ES_RUN;
      fades_started++;
    end

    b.main_phase = play_pos[47:0];
    if (wrap_on && play_pos < ovp && !first_lap) begin
      b.tail_phase = 48'(play_pos + loop_end - ovp);
      b.main_pan = pan_value(play_pos, d);
    end else begin
      b.tail_phase = '0;
      b.main_pan = PAN_NONE;
    end
    if (fade_on) begin
      b.old_phase = old_pos[47:0];
      if (wrap_on && old_pos < ovp) begin
        b.old_tail_phase = 48'(old_pos + loop_end - ovp);
        b.old_pan = pan_value(old_pos, d);
      end else begin
        b.old_tail_phase = '0;
        b.old_pan = PAN_NONE;
      end
      b.fade_pan = pan_value(fade_cnt <<< 16, d);
    end else begin
      b.old_phase = '0;
      b.old_tail_phase = '0;
      b.old_pan = PAN_NONE;
      b.fade_pan = PAN_NONE;
    end
    b.moving = (play_code == ES_RUN);

    // Advance the main position.
    play_code = ES_RUN;
    s = play_pos + r;
    if (wrap_on) begin
      play_pos = wrap_step(s, loop_start, loop_end);
      if (play_pos != s) wraps_seen++;
    end else begin
      if (s < loop_start) begin
        s = loop_start;
        play_code = ES_START;
      end
      if (s > loop_end) begin
        s = loop_end;
        play_code = ES_END;
      end
      play_pos = s;
    end
    if (first_lap && play_pos > ovp) first_lap = 1'b0;

    // The old position keeps running until the crossfade has finished.
    if (fade_on) begin
      o = old_pos;
      if (old_code == ES_RUN) o = o + r;
      fade_cnt = (fade_cnt + 1) & M24;
      if (fade_cnt >= ov) fade_on = 1'b0;
      if (wrap_on) begin
        lim = loop_end - ovp;
        old_pos = wrap_step(o, loop_start, lim);
      end else begin
        if (o >= loop_end) begin
          o = loop_end;
          old_code = ES_END;
        end else if (o <= loop_start) begin
          o = loop_start;
          old_code = ES_START;
        end
        old_pos = o & M48;
      end
    end
    last_trig = trig;
    return b;
  endfunction

  // Receiver: random stall bursts, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_request && hold_cycles == 0 && stall_left == 0) begin
      hold_cycles <= 400;
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 1) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_cycles == 1) begin
      hold_cycles <= 0;
      hold_request <= 1'b0;
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rst_ni;
    end
  end

  // Result checker: every accepted beat is compared with the oldest prediction.
  always @(posedge clk_i) begin
    phasor_beat_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_beats.size() == 0) begin
        $error("result beat arrived with no prediction waiting");
        fail_count++;
      end else begin
        want = pending_beats.pop_front();
        beats_checked++;
        if (out_ch.main_phase !== want.main_phase) begin
          $error("main_phase: expected %h, got %h", want.main_phase, out_ch.main_phase);
          fail_count++;
        end
        if (out_ch.tail_phase !== want.tail_phase) begin
          $error("tail_phase: expected %h, got %h", want.tail_phase, out_ch.tail_phase);
          fail_count++;
        end
        if (out_ch.main_pan !== want.main_pan) begin
          $error("main_pan: expected %h, got %h", want.main_pan, out_ch.main_pan);
          fail_count++;
        end
        if (out_ch.old_phase !== want.old_phase) begin
          $error("old_phase: expected %h, got %h", want.old_phase, out_ch.old_phase);
          fail_count++;
        end
        if (out_ch.old_tail_phase !== want.old_tail_phase) begin
          $error("old_tail_phase: expected %h, got %h", want.old_tail_phase,
                 out_ch.old_tail_phase);
          fail_count++;
        end
        if (out_ch.old_pan !== want.old_pan) begin
          $error("old_pan: expected %h, got %h", want.old_pan, out_ch.old_pan);
          fail_count++;
        end
        if (out_ch.fade_pan !== want.fade_pan) begin
          $error("fade_pan: expected %h, got %h", want.fade_pan, out_ch.fade_pan);
          fail_count++;
        end
        if (out_ch.moving !== want.moving) begin
          $error("moving: expected %b, got %b", want.moving, out_ch.moving);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long without any beat moving on either channel ends the run.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Sends one sample beat; an optional idle gap comes first. The prediction is
  // made at the edge where the beat is accepted.
  task automatic send_sample(input logic trig, input logic signed [23:0] rate);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.trigger_high <= trig;
    in_ch.step_rate <= rate;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_beats.push_back(advance_phasor(trig, rate));
    beats_sent++;
  endtask

  // Lets every predicted beat arrive, then waits out any work still in flight.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input longint value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[47:0];
    @(posedge clk_i);
    case (idx)
      CFG_START:   loop_start = value & M48;
      CFG_END:     loop_end = value & M48;
      CFG_RESET:   jump_pos = value & M48;
      CFG_LOOP:    wrap_on = value[0];
      CFG_OVERLAP: fade_len = value & M24;
      CFG_INITFWD: fwd_at_init = value[0];
      default: ;
    endcase
  endtask

  // Writes all six registers in index order while the block is idle.
  task automatic configure(input longint st, input longint en, input longint jp,
                           input logic lp, input longint ov, input logic fw);
    drain();
    write_reg(CFG_START, st);
    write_reg(CFG_END, en);
    write_reg(CFG_RESET, jp);
    write_reg(CFG_LOOP, longint'(lp));
    write_reg(CFG_OVERLAP, ov);
    write_reg(CFG_INITFWD, longint'(fw));
    cfg_we_i <= 1'b0;
    repeat (2) @(posedge clk_i);
  endtask

  // Random loop settings, mostly small ranges near zero so the tail shows up.
  task automatic random_setting(input logic lp);
    longint st, span, jp, ov;
    st = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(0, 1 << 22))
                                     : longint'($urandom_range(0, 1 << 18));
    span = longint'($urandom_range(2, 300)) << 16 | longint'($urandom_range(0, 65535));
    jp = st + longint'($urandom_range(0, 1 << 20)) - longint'($urandom_range(0, 1 << 17));
    if (jp < 0) jp = 0;
    ov = longint'($urandom_range(0, 160));
    configure(st, st + span, jp, lp, ov, 1'($urandom));
  endtask

  function automatic logic signed [23:0] random_rate();
    case ($urandom_range(0, 9))
      0, 1:    return 24'($urandom);
      2:       return '0;
      3, 4, 5: return -24'($urandom_range(0, 1 << 19));
      default: return 24'($urandom_range(0, 1 << 19));
    endcase
  endfunction

  // A run of samples: the trigger starts low and toggles at random, and the rate changes at random.
  task automatic send_run(input int count);
    logic trig;
    logic signed [23:0] rate;
    int i;
    trig = 1'b0;
    rate = random_rate();
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) trig = ~trig;
      if ($urandom_range(0, 5) == 0) rate = random_rate();
      send_sample(trig, rate);
    end
  endtask

  // Rate extremes, both triggers, loop tail, overlap edge sizes, first lap,
  // clamping at both ends and an empty range.
  task automatic test_directed();
    configure(64'd2 << 16, 64'd20 << 16, 64'd1 << 16, 1'b1, 64'd4, 1'b1);
    send_sample(1'b0, 24'sd65536);
    send_sample(1'b1, 24'sd65536);
    send_sample(1'b1, 24'sd8388607);
    send_sample(1'b0, -24'sd8388608);
    send_sample(1'b1, 24'sd0);
    send_sample(1'b1, -24'sd40000);
    send_sample(1'b0, 24'sd131072);
    send_sample(1'b1, 24'sd131072);
    send_sample(1'b1, 24'sd131072);
    configure(0, 64'd10 << 16, 0, 1'b1, 64'd1, 1'b1);
    send_sample(1'b0, 24'sd30000);
    send_sample(1'b1, 24'sd30000);
    send_sample(1'b1, -24'sd70000);
    configure(64'd3 << 16, 64'd9 << 16, 64'd2 << 16, 1'b0, 64'd2, 1'b0);
    send_sample(1'b0, -24'sd8388608);
    send_sample(1'b1, 24'sd65536);
    send_sample(1'b1, 24'sd8388607);
    send_sample(1'b0, 24'sd8388607);
    send_sample(1'b1, -24'sd8388608);
    configure(64'd7 << 16, 64'd7 << 16, 0, 1'b1, 64'd3, 1'b1);
    send_sample(1'b0, 24'sd5000);
    send_sample(1'b1, -24'sd5000);
    configure(64'd9 << 16, 64'd4 << 16, 64'd12 << 16, 1'b0, 64'd3, 1'b1);
    send_sample(1'b0, 24'sd5000);
    send_sample(1'b1, -24'sd5000);
    send_sample(1'b0, 24'sd0);
  endtask

  task automatic test_loop_random();
    int k;
    for (k = 0; k < 8; k++) begin
      random_setting(1'b1);
      send_run(70);
    end
  endtask

  task automatic test_clamp_random();
    int k;
    for (k = 0; k < 4; k++) begin
      random_setting(1'b0);
      send_run(60);
    end
  endtask

  // Widest values: full 48-bit ends and jump, largest overlap register.
  task automatic test_extremes();
    configure(0, M48, M48, 1'b1, M24, 1'b1);
    send_run(20);
    configure(M48, M48, 0, 1'b0, M24, 1'b0);
    send_run(15);
    configure(longint'({$urandom, $urandom}) & M48, M48, longint'({$urandom, $urandom}) & M48,
              1'b1, longint'($urandom) & M24, 1'b1);
    send_run(20);
    configure(0, 64'h8000_0000_0000, 0, 1'b0, M24, 1'b1);
    send_run(15);
  endtask

  // The receiver holds off while samples keep coming, so the input stalls.
  task automatic test_backpressure();
    random_setting(1'b1);
    hold_request <= 1'b1;
    send_run(40);
  endtask

  task automatic test_steady();
    random_setting(1'b1);
    idle_on = 1'b0;
    send_run(315);
  endtask

  initial begin
    wrap_on = 1'b0;
    fwd_at_init = 1'b1;
    loop_start = 0;
    loop_end = 0;
    jump_pos = 0;
    fade_len = 0;
    last_trig = 1'b1;
    play_pos = 0;
    play_code = ES_RUN;
    fade_on = 1'b0;
    old_pos = 0;
    fade_cnt = 0;
    old_code = ES_RUN;
    first_lap = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_loop_random();
    test_clamp_random();
    test_extremes();
    test_backpressure();
    test_steady();
    drain();

    $display("Checked %0d of %0d sample beats under loop, clamp and extreme settings.",
             beats_checked, beats_sent);
    $display("Crossfades started: %0d, loop wraps predicted: %0d, field errors: %0d.",
             fades_started, wraps_seen, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
